### rtl/serial_frame_address_crc_check_core_assert.svh
//------------------------------------------------------------------------------
// Serial frame check assertion macros
// Concurrent assertion shorthands on clock with synchronous reset disable.
//------------------------------------------------------------------------------
`ifndef SERIAL_FRAME_ADDRESS_CRC_CHECK_CORE_ASSERT_SVH
`define SERIAL_FRAME_ADDRESS_CRC_CHECK_CORE_ASSERT_SVH

// same-cycle implication
`define SFAC_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFAC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sfac_pkg.sv
//------------------------------------------------------------------------------
// Serial frame check package
// Item types, status codes, register indexes and the CRC-16 byte update.
//------------------------------------------------------------------------------
package sfac_pkg;

   localparam int unsigned    FRAME_LEN_W = 9;
   localparam logic [8:0]     MAX_FRAME   = 9'd256;
   localparam logic [8:0]     MIN_FRAME   = 9'd3;
   localparam logic [15:0]    CRC_START   = 16'hFFFF;
   localparam logic [15:0]    CRC_POLY    = 16'hA001;
   localparam logic [7:0]     SLAVE_ID_RESET  = 8'h01;
   localparam logic [7:0]     BROADCAST_RESET = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_ADDR  = 2'd1,
      STATUS_CRC   = 2'd2,
      STATUS_SHORT = 2'd3
   } status_type;

   typedef enum logic {
      CSR_SLAVE_ID  = 1'b0,
      CSR_BROADCAST = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      status_type             status;
      logic                   is_broadcast;
      logic [FRAME_LEN_W-1:0] frame_length;
   } rsp_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/serial_frame_address_crc_check_core.sv
//------------------------------------------------------------------------------
// Serial frame address and CRC check core
// Takes one received frame byte per item with an end flag on the last byte.
// Tracks the frame address, runs CRC-16 (poly 0xA001, start 0xFFFF) over all
// bytes but the final two, and checks those two against it, low byte first.
// Channels: req_ carries data_byte and last_byte, rsp_ carries accepted,
// status, is_broadcast and frame_length, one result item per frame.
// csr_ writes slave_id (index 0) and broadcast_address (index 1); always ready.
// Throughput: one byte item per cycle while req_stall is low; the CRC byte
// update is combinational between the frame state and the result register.
// Results: registered in the output register, or in the skid entry while it stalls.
// Stall: results wait in an output register plus one skid entry; req_stall
// rises only when both hold a result, so bytes keep flowing under a short stall.
// Reset: clears frame state and results; slave_id becomes 1 and
// broadcast_address 255.
//------------------------------------------------------------------------------
module serial_frame_address_crc_check_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfac_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sfac_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);
   import sfac_pkg::*;

   `include "serial_frame_address_crc_check_core_assert.svh"

   logic [7:0] slave_id_val_ff;
   logic [7:0] bcast_ff;
   logic       take;
   logic       push;
   logic       full;
   rsp_type    push_data;

   assign csr_ready   = 1'b1;
   assign req_stall   = full;
   assign take        = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_val_ff <= SLAVE_ID_RESET;
         bcast_ff        <= BROADCAST_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLAVE_ID:  slave_id_val_ff <= csr_data;
            CSR_BROADCAST: bcast_ff        <= csr_data;
            default:       bcast_ff        <= bcast_ff;
         endcase
      end
   end

   sfac_frame u_frame (
      .clock             (clock),
      .reset             (reset),
      .take              (take),
      .req_data          (req_data),
      .slave_id          (slave_id_val_ff),
      .broadcast_address (bcast_ff),
      .push              (push),
      .push_data         (push_data)
   );

   sfac_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `SFAC_ASSERT_SAME(a_stall_needs_result, req_stall, rsp_valid, "input stalled with no result held")
   `SFAC_ASSERT_SAME(a_accept_matches_ok, rsp_valid, rsp_data.accepted == (rsp_data.status == STATUS_OK), "accepted flag disagrees with status")
   `SFAC_ASSERT_NEXT(a_last_gives_result, req_valid && !req_stall && req_data.last_byte, rsp_valid, "no result after last byte")
   `SFAC_ASSERT_SAME(a_length_nonzero, rsp_valid, rsp_data.frame_length != '0, "result with zero frame length")

endmodule

### rtl/sfac_frame.sv
//------------------------------------------------------------------------------
// Serial frame check state
// Frame address, two-byte delay, running CRC and byte count; builds the
// result on the last byte and clears for the next frame.
//------------------------------------------------------------------------------
module sfac_frame (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  sfac_pkg::req_type req_data,
   input  logic [7:0]       slave_id,
   input  logic [7:0]       broadcast_address,
   output logic             push,
   output sfac_pkg::rsp_type push_data
);
   import sfac_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [15:0] dly_ff, dly_in;
   logic [7:0]  addr_ff, addr_in;
   logic [FRAME_LEN_W-1:0] count_ff, count_in;
   status_type  status;
   logic        bcast;

   always_comb begin
      addr_in  = (count_ff == '0) ? req_data.data_byte : addr_ff;
      crc_in   = (count_ff >= 9'd2) ? crc_feed(crc_ff, dly_ff[15:8]) : crc_ff;
      dly_in   = {dly_ff[7:0], req_data.data_byte};
      count_in = (count_ff < MAX_FRAME) ? count_ff + 9'd1 : count_ff;

      bcast = (addr_in == broadcast_address);
      if (count_in < MIN_FRAME) begin
         status = STATUS_SHORT;
      end else if (addr_in != slave_id && !bcast) begin
         status = STATUS_ADDR;
      end else if (dly_in[15:8] != crc_in[7:0] || dly_in[7:0] != crc_in[15:8]) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
      end

      push                   = take && req_data.last_byte;
      push_data.accepted     = (status == STATUS_OK);
      push_data.status       = status;
      push_data.is_broadcast = bcast;
      push_data.frame_length = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_START;
         dly_ff   <= '0;
         addr_ff  <= '0;
         count_ff <= '0;
      end else if (take) begin
         if (req_data.last_byte) begin
            crc_ff   <= CRC_START;
            dly_ff   <= '0;
            addr_ff  <= '0;
            count_ff <= '0;
         end else begin
            crc_ff   <= crc_in;
            dly_ff   <= dly_in;
            addr_ff  <= addr_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

### rtl/sfac_rsp_buf.sv
//------------------------------------------------------------------------------
// Serial frame check result buffer
// Output register with one skid entry; stalls the input only when both hold.
//------------------------------------------------------------------------------
module sfac_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfac_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sfac_pkg::rsp_type rsp_data
);
   import sfac_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= push_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= push_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule
